// ----- rtl/jsc_pkg.sv -----
// shared types and constants for the julian seconds to calendar date converter
package jsc_pkg;

  // input format codes
  localparam logic [1:0] FMT_JD  = 2'd0;
  localparam logic [1:0] FMT_RJD = 2'd1;
  localparam logic [1:0] FMT_MJD = 2'd2;

  // epoch offsets in seconds, each already holding the extra half day
  localparam logic [40:0] HALF_DAY_SEC = 41'd43200;
  localparam logic [40:0] RJD_OFFS_SEC = 41'(64'd2400000 * 64'd86400 + 64'd43200);
  localparam logic [40:0] MJD_OFFS_SEC = 41'(64'd2400000 * 64'd86400 + 64'd86400);

  // reciprocals for constant division by multiply and shift
  localparam logic [30:0] RECIP_675    = 31'((64'd1 << 40) / 64'd675);
  localparam logic [26:0] RECIP_146097 = 27'(((64'd1 << 44) + 64'd146096) / 64'd146097);
  localparam logic [26:0] RECIP_1461   = 27'(((64'd1 << 37) + 64'd1460) / 64'd1461);
  localparam logic [13:0] RECIP_225    = 14'(((64'd1 << 21) + 64'd224) / 64'd225);
  localparam logic [10:0] RECIP_15     = 11'(((64'd1 << 14) + 64'd14) / 64'd15);
  localparam logic [11:0] RECIP_153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [8:0]  RECIP_5      = 9'(((64'd1 << 11) + 64'd4) / 64'd5);

  // richards algorithm constants
  localparam logic [25:0] RG_B      = 26'd274277;
  localparam logic [23:0] RG_J_C    = 24'd1363;   // j plus c
  localparam logic [16:0] RG_Y      = 17'd4716;

  // pipeline depth
  localparam int NSTAGE = 10;

  // one result item, year in the lowest bits
  typedef struct packed {
    logic        [5:0]  second;
    logic        [5:0]  minute;
    logic        [4:0]  hour;
    logic        [4:0]  day;
    logic        [3:0]  month;
    logic signed [16:0] year;
  } result_t;

endpackage

// ----- rtl/julian_seconds_to_calendar_date_core.sv -----
// julian seconds to gregorian date and time of day, ten stage pipeline
//
// Usage:
//   s_axis carries one time in whole seconds per transfer (tdata[39:0]).
//   m_axis returns one result per input, in order, on tdata[42:0].
//   cfg_valid/cfg_data write the input format (0 julian date, 1 reduced,
//   2 modified, 3 acts as 0); cfg_ready is always high. Write it only
//   while no item is in flight.
// Timing:
//   m_axis_tvalid rises once an input item has passed through the stage
//   registers p0 to p9; the result transfers when m_axis_tready is high.
//   throughput is one item per cycle while m_axis_tready is high; after
//   the first stage adds the offset, most constant divides are a multiply
//   by a reciprocal in one stage and a correction in the next.
// Reset:
//   rst clears every stage valid bit and sets the format to julian date.
// Stall:
//   when m_axis_tready is low the result holds in the output register;
//   each stage still moves forward into an empty slot ahead of it, so empty
//   slots fill up and s_axis_tready drops only once every stage is full.
module julian_seconds_to_calendar_date_core
  import jsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,       // input_format
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // time_value[39:0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // year[16:0] month[20:17] day[25:21]
                                      // hour[30:26] minute[36:31] second[42:37]
);

  logic [1:0]        input_format;
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] adv;

  // stage registers
  logic [40:0] p0_total;
  logic [23:0] p1_q0;
  logic [11:0] p1_x12;
  logic [6:0]  p1_r7;
  logic [23:0] p2_jd;
  logic [16:0] p2_sod;
  logic [23:0] p3_jd;
  logic [52:0] p3_cprod;
  logic [26:0] p3_hprod;
  logic [16:0] p3_sod;
  logic [25:0] p4_e;
  logic [11:0] p4_remh;
  logic [4:0]  p4_hour;
  logic [52:0] p5_yprod;
  logic [10:0] p5_e11;
  logic [20:0] p5_mprod;
  logic [5:0]  p5_remh6;
  logic [4:0]  p5_hour;
  logic [15:0] p6_ye;
  logic [10:0] p6_h;
  logic [4:0]  p6_hour;
  logic [5:0]  p6_minute;
  logic [5:0]  p6_second;
  logic [15:0] p7_ye;
  logic [3:0]  p7_hq;
  logic [7:0]  p7_h8;
  logic [4:0]  p7_hour;
  logic [5:0]  p7_minute;
  logic [5:0]  p7_second;
  logic signed [16:0] p8_year;
  logic [3:0]  p8_month;
  logic [7:0]  p8_hrem;
  logic [4:0]  p8_hour;
  logic [5:0]  p8_minute;
  logic [5:0]  p8_second;
  result_t     p9_res;

  // combinational values between stages
  logic [40:0] offs;
  logic [54:0] s1_prod;
  logic [11:0] s2_rem12;
  logic [11:0] s2_q675;
  logic [23:0] s2_jd;
  logic [9:0]  s2_rem;
  logic [25:0] s3_a;
  logic [8:0]  s4_c;
  logic [10:0] s4_c3;
  logic [23:0] s4_f;
  logic [11:0] s4_h3600;
  logic [10:0] s6_y1461;
  logic [10:0] s6_grem;
  logic [10:0] s6_h;
  logic [5:0]  s6_minute;
  logic [5:0]  s6_m60;
  logic [22:0] s7_hprod;
  logic [7:0]  s8_q153;
  logic [3:0]  s8_month;
  logic [16:0] s9_dprod;
  logic [4:0]  s9_day;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_format <= FMT_JD;
    end else if (cfg_valid && cfg_ready) begin
      input_format <= cfg_data;
    end
  end

  // per stage advance: a stage loads when it is empty or its successor moves
  always_comb begin
    adv[NSTAGE-1] = !vld[NSTAGE-1] || m_axis_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[NSTAGE-1];
  assign m_axis_tdata  = {5'b0, p9_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // epoch offset plus half a day
  always_comb begin
    case (input_format)
      FMT_RJD: offs = RJD_OFFS_SEC;
      FMT_MJD: offs = MJD_OFFS_SEC;
      default: offs = HALF_DAY_SEC;
    endcase
  end

  // day split: estimate from top bits, then at most two corrections
  assign s1_prod  = 55'(p0_total[40:17]) * 55'(RECIP_675);
  assign s2_q675  = p1_q0[11:0] * 12'd675;
  assign s2_rem12 = p1_x12 - s2_q675;

  always_comb begin
    if (s2_rem12 >= 12'd1350) begin
      s2_jd  = p1_q0 + 24'd2;
      s2_rem = 10'(s2_rem12 - 12'd1350);
    end else if (s2_rem12 >= 12'd675) begin
      s2_jd  = p1_q0 + 24'd1;
      s2_rem = 10'(s2_rem12 - 12'd675);
    end else begin
      s2_jd  = p1_q0;
      s2_rem = s2_rem12[9:0];
    end
  end

  // century correction term of the day number
  assign s3_a     = {p2_jd, 2'b00} + RG_B;
  assign s4_c     = p3_cprod[52:44];
  assign s4_c3    = {2'b00, s4_c} + {1'b0, s4_c, 1'b0};
  assign s4_f     = p3_jd + RG_J_C + {15'b0, s4_c3[10:2]};
  assign s4_h3600 = {7'b0, p3_hprod[25:21]} * 12'd3600;

  // year count and day of year
  assign s6_y1461  = p5_yprod[47:37] * 11'd1461;
  assign s6_grem   = p5_e11 - s6_y1461;
  assign s6_h      = {2'b00, s6_grem[10:2]} + {s6_grem[10:2], 2'b00} + 11'd2;
  assign s6_minute = p5_mprod[19:14];
  assign s6_m60    = s6_minute * 6'd60;

  // month and day of month, january and february close the shifted year
  assign s7_hprod = 23'(p6_h) * 23'(RECIP_153);
  assign s8_q153  = {4'b0, p7_hq} * 8'd153;
  assign s8_month = (p7_hq >= 4'd10) ? p7_hq - 4'd9 : p7_hq + 4'd3;
  assign s9_dprod = 17'(p8_hrem) * 17'(RECIP_5);
  assign s9_day   = s9_dprod[15:11] + 5'd1;

  // payload registers
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p0_total <= {1'b0, s_axis_tdata} + offs;
    end
    if (adv[1]) begin
      p1_q0  <= s1_prod[53:30];
      p1_x12 <= p0_total[18:7];
      p1_r7  <= p0_total[6:0];
    end
    if (adv[2]) begin
      p2_jd  <= s2_jd;
      p2_sod <= {s2_rem, p1_r7};
    end
    if (adv[3]) begin
      p3_jd    <= p2_jd;
      p3_cprod <= 53'(s3_a) * 53'(RECIP_146097);
      p3_hprod <= 27'(p2_sod[16:4]) * 27'(RECIP_225);
      p3_sod   <= p2_sod;
    end
    if (adv[4]) begin
      p4_e    <= {s4_f, 2'b11};
      p4_remh <= p3_sod[11:0] - s4_h3600;
      p4_hour <= p3_hprod[25:21];
    end
    if (adv[5]) begin
      p5_yprod <= 53'(p4_e) * 53'(RECIP_1461);
      p5_e11   <= p4_e[10:0];
      p5_mprod <= 21'(p4_remh[11:2]) * 21'(RECIP_15);
      p5_remh6 <= p4_remh[5:0];
      p5_hour  <= p4_hour;
    end
    if (adv[6]) begin
      p6_ye     <= p5_yprod[52:37];
      p6_h      <= s6_h;
      p6_hour   <= p5_hour;
      p6_minute <= s6_minute;
      p6_second <= p5_remh6 - s6_m60;
    end
    if (adv[7]) begin
      p7_ye     <= p6_ye;
      p7_hq     <= s7_hprod[22:19];
      p7_h8     <= p6_h[7:0];
      p7_hour   <= p6_hour;
      p7_minute <= p6_minute;
      p7_second <= p6_second;
    end
    if (adv[8]) begin
      p8_year   <= $signed({1'b0, p7_ye}) - $signed(RG_Y)
                   + $signed({16'b0, (s8_month <= 4'd2)});
      p8_month  <= s8_month;
      p8_hrem   <= p7_h8 - s8_q153;
      p8_hour   <= p7_hour;
      p8_minute <= p7_minute;
      p8_second <= p7_second;
    end
    if (adv[9]) begin
      p9_res.year   <= p8_year;
      p9_res.month  <= p8_month;
      p9_res.day    <= s9_day;
      p9_res.hour   <= p8_hour;
      p9_res.minute <= p8_minute;
      p9_res.second <= p8_second;
    end
  end

  // an accepted transfer always lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted transfer did not enter the pipeline");

  // day split correction leaves seconds of day below one day
  a_sod_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (p2_sod < 17'd86400))
    else $error("seconds of day out of range");

  // month in range and day nonzero on every result
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (p9_res.month >= 4'd1 && p9_res.month <= 4'd12 &&
                       p9_res.day >= 5'd1))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (p9_res.hour < 5'd24 && p9_res.minute < 6'd60 &&
                       p9_res.second < 6'd60))
    else $error("time of day out of range");

endmodule
